/* hdl/hbs_pkg.sv */
// package for the hypersphere bounce step pipeline
// shared widths, register indexes, pipeline structs and saturation helpers
// no dependencies
`default_nettype none
package hbs_pkg;

  localparam int FRAC_BITS = 8;
  localparam int POS_W     = 24;
  localparam int VEL_W     = 16;
  localparam int RAD_W     = 15;
  localparam int LEN2_W    = 49;   // sum of four squared positions
  localparam int QUO_W     = 18;   // reflection term never exceeds 2^17
  localparam int NUM_W     = 65;   // twice |dot| * |p_i|
  localparam int DOT_W     = 42;
  localparam int DMAG_W    = 41;
  localparam int DIV_STEPS = QUO_W;

  // configuration register indexes
  localparam logic REG_MOTION_ENABLE = 1'b0;
  localparam logic REG_BOUND_RADIUS  = 1'b1;

  // per-item data that rides alongside the divider
  typedef struct packed {
    logic [3:0][POS_W-1:0] pos;
    logic [3:0][VEL_W-1:0] vel;
    logic                  bounced;
    logic [3:0]            neg;
  } side_t;

  // one divider stage: partial remainders, numerator bits shifting out,
  // quotient bits shifting in
  typedef struct packed {
    side_t                  side;
    logic [LEN2_W-1:0]      den;
    logic [3:0][LEN2_W-1:0] rem;
    logic [3:0][QUO_W-1:0]  nq;
  } div_t;

  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] s);
    logic [POS_W-1:0] r;
    if (s[POS_W] != s[POS_W-1]) begin
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [VEL_W+3:0] s);
    logic [VEL_W-1:0] r;
    if (s > $signed({5'b0, {(VEL_W-1){1'b1}}})) begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end else if (s < $signed({5'b11111, {(VEL_W-1){1'b0}}})) begin
      r = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      r = s[VEL_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/hbs_front.sv */
// front pipeline: motion add, squares and dot products, sums and bounce
// test, long product split, divider operand setup; uses hbs_pkg
`default_nettype none
module hbs_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [3:0][23:0]         in_pos,
  input  wire logic [3:0][15:0]         in_vel,
  input  wire logic                     motion_enable,
  input  wire logic [45:0]              rad2,
  output logic                          out_valid,
  output hbs_pkg::div_t                 out_data
);
  import hbs_pkg::*;

  // stage 1 registers
  logic                  v1_r;
  logic [3:0][POS_W-1:0] pos1_r, pos1_nxt;
  logic [3:0][VEL_W-1:0] vel1_r;
  logic                  en1_r;
  // stage 2 registers
  logic                  v2_r, en2_r;
  logic [3:0][POS_W-1:0] pos2_r;
  logic [3:0][VEL_W-1:0] vel2_r;
  logic [3:0][46:0]      sq2_r, sq2_nxt;
  logic [3:0][39:0]      pr2_r, pr2_nxt;
  // stage 3 registers
  logic                  v3_r, bnc3_r, bnc3_nxt, dneg3_r;
  logic [3:0][POS_W-1:0] pos3_r;
  logic [3:0][VEL_W-1:0] vel3_r;
  logic [LEN2_W-1:0]     len3_r, len3_nxt;
  logic [DMAG_W-1:0]     dmag3_r, dmag3_nxt;
  logic signed [DOT_W-1:0] dot3;
  logic [3:0][POS_W-1:0] pmag3_r, pmag3_nxt;
  // stage 4 registers
  logic                  v4_r, bnc4_r;
  logic [3:0][POS_W-1:0] pos4_r;
  logic [3:0][VEL_W-1:0] vel4_r;
  logic [LEN2_W-1:0]     len4_r;
  logic [3:0]            neg4_r, neg4_nxt;
  logic [3:0][55:0]      lo4_r, lo4_nxt;
  logic [3:0][31:0]      hi4_r, hi4_nxt;
  // stage 5
  logic                  v5_r;
  div_t                  d5_r, d5_nxt;
  logic [63:0]           m5;

  // stage 1: saturating position update when motion is enabled, else pass-through
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (motion_enable) begin
        pos1_nxt[i] = sat_pos({in_pos[i][POS_W-1], in_pos[i]} +
                              {{(POS_W-VEL_W+1){in_vel[i][VEL_W-1]}}, in_vel[i]});
      end else begin
        pos1_nxt[i] = in_pos[i];
      end
    end
  end

  // stage 2: squares and velocity-position products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq2_nxt[i] = 47'($signed(pos1_r[i]) * $signed(pos1_r[i]));
      pr2_nxt[i] = 40'($signed(pos1_r[i]) * $signed(vel1_r[i]));
    end
  end

  // stage 3: squared length, dot product, bounce test, magnitudes
  always_comb begin
    len3_nxt = LEN2_W'(sq2_r[0]) + LEN2_W'(sq2_r[1]) +
               LEN2_W'(sq2_r[2]) + LEN2_W'(sq2_r[3]);
    dot3 = DOT_W'($signed(pr2_r[0])) + DOT_W'($signed(pr2_r[1])) +
           DOT_W'($signed(pr2_r[2])) + DOT_W'($signed(pr2_r[3]));
    dmag3_nxt = dot3[DOT_W-1] ? DMAG_W'(-dot3) : DMAG_W'(dot3);
    bnc3_nxt  = en2_r && (len3_nxt > LEN2_W'(rad2));
    for (int i = 0; i < 4; i++) begin
      pmag3_nxt[i] = pos2_r[i][POS_W-1] ? -pos2_r[i] : pos2_r[i];
    end
  end

  // stage 4: split |dot| * |p_i| into two narrow products
  // upper part of |dot| is at most 256, so its product fits 32 bits
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lo4_nxt[i]  = dmag3_r[31:0] * pmag3_r[i];
      hi4_nxt[i]  = 32'(dmag3_r[DMAG_W-1:32] * pmag3_r[i]);
      neg4_nxt[i] = dneg3_r ^ pos3_r[i][POS_W-1];
    end
  end

  // stage 5: join partial products, load divider operands
  always_comb begin
    m5 = '0;
    d5_nxt.side.pos     = pos4_r;
    d5_nxt.side.vel     = vel4_r;
    d5_nxt.side.bounced = bnc4_r;
    d5_nxt.side.neg     = neg4_r;
    d5_nxt.den          = len4_r;
    for (int i = 0; i < 4; i++) begin
      m5 = 64'(lo4_r[i]) + {hi4_r[i], 32'b0};
      // numerator is 2*m; the top bits seed the remainder
      d5_nxt.rem[i] = LEN2_W'(m5[63:QUO_W-1]);
      d5_nxt.nq[i]  = {m5[QUO_W-2:0], 1'b0};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      pos1_r <= pos1_nxt; vel1_r <= in_vel; en1_r <= motion_enable;
      pos2_r <= pos1_r; vel2_r <= vel1_r; en2_r <= en1_r;
      sq2_r <= sq2_nxt; pr2_r <= pr2_nxt;
      pos3_r <= pos2_r; vel3_r <= vel2_r; bnc3_r <= bnc3_nxt;
      len3_r <= len3_nxt; dmag3_r <= dmag3_nxt; dneg3_r <= dot3[DOT_W-1];
      pmag3_r <= pmag3_nxt;
      pos4_r <= pos3_r; vel4_r <= vel3_r; bnc4_r <= bnc3_r; len4_r <= len3_r;
      neg4_r <= neg4_nxt; lo4_r <= lo4_nxt; hi4_r <= hi4_nxt;
      d5_r <= d5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = d5_r;

endmodule
`default_nettype wire

/* hdl/hbs_div_step.sv */
// one restoring division step for all four lanes, registered
// uses hbs_pkg
`default_nettype none
module hbs_div_step (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  hbs_pkg::div_t       in_data,
  output logic                out_valid,
  output hbs_pkg::div_t       out_data
);
  import hbs_pkg::*;

  logic  valid_r;
  div_t  data_r, data_nxt;
  logic [LEN2_W:0] trial;

  // shift in next numerator bit, subtract divisor when it fits
  always_comb begin
    trial    = '0;
    data_nxt = in_data;
    for (int i = 0; i < 4; i++) begin
      trial = {in_data.rem[i], in_data.nq[i][QUO_W-1]};
      if (trial >= {1'b0, in_data.den}) begin
        data_nxt.rem[i] = LEN2_W'(trial - {1'b0, in_data.den});
        data_nxt.nq[i]  = {in_data.nq[i][QUO_W-2:0], 1'b1};
      end else begin
        data_nxt.rem[i] = trial[LEN2_W-1:0];
        data_nxt.nq[i]  = {in_data.nq[i][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

/* hdl/hypersphere_bounce_step.sv */
// hypersphere_bounce_step: one motion step of a particle bounded by a 4D sphere
// Input transaction: position (Q15.8) and velocity (Q7.8) of one particle.
// Output transaction: new position, new velocity and the bounce flag.
// Each item enters a 24-stage pipeline: five front stages (add, multiply,
// sum, split product, operand join), eighteen restoring divider steps (one
// quotient bit each, four lanes side by side) and the output register.
// Throughput is one item per cycle while the receiver takes every result.
// The whole pipeline advances together: when the output register holds a
// transaction that the receiver does not take, every stage holds and
// in_tready drops; nothing is lost or repeated. Bubbles travel as invalid.
// Configuration: cfg_we writes register cfg_addr (0 motion enable,
// 1 bound radius) at the clock edge; the squared radius follows in the next cycle,
// so write only while no transaction is in flight.
// Reset (rst_n low, synchronous) empties the pipeline, disables motion
// and sets the radius to 500.
// depends on hbs_pkg, hbs_front, hbs_div_step
`default_nettype none
module hypersphere_bounce_step (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // pos_x, pos_y, pos_z, pos_w, vel_x, vel_y, vel_z, vel_w
  input  wire logic [159:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // new_pos_x..new_pos_w, new_vel_x..new_vel_w
  output logic [159:0]      out_tdata,
  // bounced
  output logic              out_tuser,
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [14:0]  cfg_wdata
);
  import hbs_pkg::*;

  logic                    en;
  logic                    motion_en_r;
  logic [RAD_W-1:0]        radius_r;
  logic [45:0]             rad2_r;
  logic [RAD_W+FRAC_BITS-1:0] rad_fx;
  logic [3:0][POS_W-1:0]   in_pos;
  logic [3:0][VEL_W-1:0]   in_vel;
  logic                    dv [0:DIV_STEPS];
  div_t                    dd [0:DIV_STEPS];
  logic                    out_valid_r;
  logic [3:0][POS_W-1:0]   out_pos_r;
  logic [3:0][VEL_W-1:0]   out_vel_r, out_vel_nxt;
  logic                    out_bnc_r;
  side_t                   fin;
  logic signed [QUO_W:0]   term;
  logic signed [VEL_W+3:0] diff;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign in_pos    = in_tdata[4*POS_W-1:0];
  assign in_vel    = in_tdata[159:4*POS_W];

  // configuration registers and squared radius
  assign rad_fx = {radius_r, {FRAC_BITS{1'b0}}};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_en_r <= 1'b0;
      radius_r    <= RAD_W'(500);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MOTION_ENABLE: motion_en_r <= cfg_wdata[0];
        REG_BOUND_RADIUS:  radius_r    <= cfg_wdata;
        default:           motion_en_r <= motion_en_r;
      endcase
    end
  end
  always_ff @(posedge clk) begin
    rad2_r <= rad_fx * rad_fx;
  end

  hbs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_tvalid),
    .in_pos        (in_pos),
    .in_vel        (in_vel),
    .motion_enable (motion_en_r),
    .rad2          (rad2_r),
    .out_valid     (dv[0]),
    .out_data      (dd[0])
  );

  // divider chain, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    hbs_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv[k]),
      .in_data   (dd[k]),
      .out_valid (dv[k+1]),
      .out_data  (dd[k+1])
    );
  end

  // reflected velocity with saturation on a bounce, else velocity unchanged
  assign fin = dd[DIV_STEPS].side;
  always_comb begin
    term = '0;
    diff = '0;
    for (int i = 0; i < 4; i++) begin
      term = fin.neg[i] ? -$signed({1'b0, dd[DIV_STEPS].nq[i]})
                        :  $signed({1'b0, dd[DIV_STEPS].nq[i]});
      diff = (VEL_W+4)'($signed(fin.vel[i])) - (VEL_W+4)'(term);
      out_vel_nxt[i] = fin.bounced ? sat_vel(diff) : fin.vel[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[DIV_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_r <= fin.pos;
      out_vel_r <= out_vel_nxt;
      out_bnc_r <= fin.bounced;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_vel_r, out_pos_r};
  assign out_tuser  = out_bnc_r;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// testbench for hypersphere_bounce_step: drives particle transactions through
// the stream ports, predicts each result with its own fixed-point model and checks it
// depends on hbs_pkg and the hypersphere_bounce_step rtl
`timescale 1ns / 100ps
`default_nettype none

// holds predicted particle updates and compares them with the block output
class bounce_scoreboard;
  bit          motion_on;
  logic [14:0] radius;
  logic [160:0] pending[$];
  int          mismatches;

  function new();
    motion_on  = 1'b0;
    radius     = 15'd500;
    mismatches = 0;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // work out new position, velocity and bounce flag for one particle
  function void note_particle(logic [159:0] d);
    longint p[4];
    longint v[4];
    longint nv[4];
    longint dot;
    longint q;
    longint term;
    logic [127:0] len2;
    logic [127:0] lim;
    logic [127:0] num;
    logic [127:0] dmag;
    logic [127:0] pm;
    logic [160:0] res;
    bit bnc;
    bnc = 1'b0;
    for (int i = 0; i < 4; i++) begin
      p[i]  = longint'($signed(d[24*i +: 24]));
      v[i]  = longint'($signed(d[96 + 16*i +: 16]));
      nv[i] = v[i];
    end
    if (motion_on) begin
      len2 = '0;
      lim = 128'(radius) << 8;
      lim = lim * lim;
      for (int i = 0; i < 4; i++) begin
        p[i] = clamp(p[i] + v[i], 24);
        len2 += 128'(p[i] * p[i]);
      end
      if (len2 > lim) begin
        bnc = 1'b1;
        dot = 0;
        for (int i = 0; i < 4; i++) dot += v[i] * p[i];
        dmag = 128'(dot < 0 ? -dot : dot);
        for (int i = 0; i < 4; i++) begin
          pm   = 128'(p[i] < 0 ? -p[i] : p[i]);
          num  = 2 * dmag * pm;
          q    = longint'(num / len2);
          term = ((dot < 0) != (p[i] < 0)) ? -q : q;
          nv[i] = clamp(v[i] - term, 16);
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      res[24*i +: 24]      = p[i][23:0];
      res[96 + 16*i +: 16] = nv[i][15:0];
    end
    res[160] = bnc;
    pending.insert(pending.size(), res);
  endfunction

  // compare one result transaction with the oldest prediction
  function void check_result(logic [159:0] d, logic u);
    logic [160:0] exp_res;
    logic [160:0] got;
    got = {u, d};
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_res = pending.pop_front();
    if (got !== exp_res) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch exp %h got %h", exp_res, got);
    end
  endfunction
endclass

module tb_top;
  import hbs_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [159:0] out_tdata;
  logic         out_tuser;
  logic         cfg_we;
  logic         cfg_addr;
  logic [14:0]  cfg_wdata;

  bounce_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off;
  longint cycles;

  hypersphere_bounce_step u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("[hypersphere_bounce_step] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [14:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MOTION_ENABLE) sb.motion_on = val[0];
    else sb.radius = val;
    @(posedge clk);
  endtask

  // offer one particle and wait for acceptance
  task automatic send_particle(logic [159:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_particle(d);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [159:0] pack_particle(logic [3:0][23:0] p,
                                                 logic [3:0][15:0] v);
    return {v, p};
  endfunction

  // mostly near-sphere particles so bounces are common, some raw noise
  function automatic logic [159:0] rand_particle(logic [14:0] rad);
    logic [3:0][23:0] p;
    logic [3:0][15:0] v;
    int sel;
    sel = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      if (sel < 2) begin
        p[i] = 24'($urandom);
        v[i] = 16'($urandom);
      end else begin
        p[i] = 24'($signed(int'($urandom_range(2 * rad * 160)) - int'(rad * 160)));
        v[i] = (sel < 5) ? 16'($urandom) :
               16'($signed(int'($urandom_range(4000)) - 2000));
      end
    end
    return pack_particle(p, v);
  endfunction

  task automatic run_random(int n, logic [14:0] rad);
    for (int k = 0; k < n; k++) send_particle(rand_particle(rad));
  endtask

  initial begin
    logic [14:0] rads[4];
    sb = new();
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_we = 1'b0; cfg_addr = 1'b0; cfg_wdata = '0;
    hold_off = 1'b0; cycles = 0;
    send_idle_pct = 18; recv_idle_pct = 71;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pass-through at reset, then extremes and special cases
    send_particle({{4{16'h8000}}, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000});
    drain();
    write_reg(REG_MOTION_ENABLE, 15'd1);
    send_particle(pack_particle({4{24'h0}}, {4{16'h0}}));
    send_particle(pack_particle({24'h0, 24'h0, 24'h0, 24'd127744}, {16'h0, 16'h0, 16'h0, 16'd256}));
    send_particle(pack_particle({24'h0, 24'h0, 24'h0, 24'd127744}, {16'h0, 16'h0, 16'h0, 16'd257}));
    send_particle(pack_particle({4{24'h7fffff}}, {4{16'h7fff}}));
    send_particle(pack_particle({4{24'h800000}}, {4{16'h8000}}));
    send_particle(pack_particle({24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000},
                                {16'h7fff, 16'h8000, 16'h8000, 16'h7fff}));
    send_particle(pack_particle({24'h0, 24'h0, 24'h0, 24'd200000}, {16'h0, 16'h0, 16'h0, 16'h7fff}));
    send_particle(pack_particle({24'h0, 24'h0, 24'd1, 24'h0}, {16'h0, 16'h0, 16'h8000, 16'h0}));
    drain();
    write_reg(REG_BOUND_RADIUS, 15'd32767);
    send_particle(pack_particle({4{24'h7fffff}}, {4{16'h7fff}}));
    send_particle(pack_particle({24'h0, 24'h0, 24'h0, 24'h7fff00}, {16'h0, 16'h0, 16'h0, 16'h00ff}));
    drain();
    write_reg(REG_BOUND_RADIUS, 15'd1);
    send_particle(pack_particle({24'h0, 24'h0, 24'h0, 24'd256}, {16'h0, 16'h0, 16'h0, 16'h0}));
    send_particle(pack_particle({24'h0, 24'h0, 24'h0, 24'd257}, {16'h0, 16'h0, 16'h0, 16'h8000}));
    send_particle(pack_particle({24'h0, 24'h0, 24'd3, 24'h800000}, {16'h7fff, 16'h1, 16'h8000, 16'h8000}));
    drain();
    write_reg(REG_BOUND_RADIUS, 15'd0);
    send_particle(pack_particle({24'h0, 24'h0, 24'h0, 24'd1}, {16'h0, 16'h0, 16'h0, 16'h0}));
    send_particle(pack_particle({4{24'h0}}, {4{16'h0}}));
    drain();

    // random phases over several settings, three idling profiles
    rads[0] = 15'd1; rads[1] = 15'd500; rads[2] = 15'd32767; rads[3] = 15'd9000;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 71 : 0;
      recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 18 : 0;
      for (int r = 0; r < 4; r++) begin
        write_reg(REG_BOUND_RADIUS, rads[r]);
        write_reg(REG_MOTION_ENABLE, (r == 3 && ph == 1) ? 15'd0 : 15'd1);
        if (ph == 2 && r == 1) begin
          // long receiver hold-off while the sender keeps offering
          fork
            begin
              hold_off = 1'b1;
              repeat (200) @(posedge clk);
              hold_off = 1'b0;
            end
            run_random(130, 15'd500);
          join
        end
        run_random(100, rads[r] == 0 ? 15'd1 : (rads[r] > 15'd20000 ? 15'd20000 : rads[r]));
        drain();
      end
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[hypersphere_bounce_step] OK");
    end else begin
      $display("[hypersphere_bounce_step] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
